@@ sv/bdh_pkg.sv @@
// Package for the button debounce and hold block.
// Holds the per-button state code, sizes and register indexes.
// No dependencies.
package bdh_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int IDX_W       = 3;
    localparam int TIME_W      = 32;
    localparam int LIMIT_W     = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT     = 1'd1;

    localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST = 16'd50;
    localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST     = 16'd2000;

    typedef enum logic [2:0] {
        ST_UP       = 3'd0,
        ST_PRESSED  = 3'd1,
        ST_DEBOUNCE = 3'd2,
        ST_DOWN     = 3'd3,
        ST_HELD     = 3'd4,
        ST_RELEASED = 3'd5
    } btn_state_t;

endpackage

@@ sv/bdh_if.sv @@
// Valid/ready channel interfaces for the button debounce and hold block.
// Sample channel in, result channel out. Depends on bdh_pkg.
interface bdh_sample_if;
    logic                        valid;
    logic                        ready;
    logic [bdh_pkg::IDX_W-1:0]   button_index;
    logic                        pin_level;
    logic [bdh_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, output button_index, output pin_level, output now_ms,
                    input ready);
    modport sink   (input valid, input button_index, input pin_level, input now_ms,
                    output ready);
endinterface

interface bdh_result_if;
    logic                        valid;
    logic                        ready;
    logic [bdh_pkg::IDX_W-1:0]   out_index;
    logic [2:0]                  new_state;

    modport source (output valid, output out_index, output new_state, input ready);
    modport sink   (input valid, input out_index, input new_state, output ready);
endinterface

@@ sv/button_debounce_hold_fsm_core.sv @@
// Multi-button debouncer with long-press detection, top level.
// Per-button state and press timestamp live in two synchronous memories.
// Depends on bdh_pkg and the channel interfaces in bdh_if.sv.
//
// Usage:
//   sample channel: one transaction per pin sample (button index, raw active-low
//   pin level, free-running millisecond time). result channel: one transaction
//   per sample with the button index and its new state code.
//   Config port: cfg_we/cfg_index/cfg_data write debounce (0) or hold (1) limit;
//   write only while no transaction is in flight.
// Timing:
//   A sample accepted reads both memories into the compute stage; when that stage
//   fires, the state is written back and the result goes to the output register.
//   While results are taken, throughput is one sample per cycle, back to back, also
//   on the same button: the last write-back is forwarded over the memory read.
// Reset:
//   All buttons read as up (per-entry valid flags); limits go to 50 and 2000 ms.
// Stall:
//   When the result receiver stalls, the output register and the compute stage
//   hold; the sample channel stays ready until both are full.
module button_debounce_hold_fsm_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bdh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bdh_pkg::LIMIT_W-1:0]         cfg_data,
    bdh_sample_if.sink                          sample,
    bdh_result_if.source                        result
);

    localparam int N = bdh_pkg::NUM_BUTTONS;

    bdh_pkg::btn_state_t            state_mem [N];
    logic [bdh_pkg::TIME_W-1:0]     time_mem  [N];
    logic [N-1:0]                   vld_reg;

    logic [bdh_pkg::LIMIT_W-1:0]    deb_limit_reg;
    logic [bdh_pkg::LIMIT_W-1:0]    hold_limit_reg;

    // compute stage
    logic                           s1_valid_reg;
    logic [bdh_pkg::IDX_W-1:0]      s1_idx_reg;
    logic                           s1_pin_reg;
    logic [bdh_pkg::TIME_W-1:0]     s1_now_reg;
    bdh_pkg::btn_state_t            rd_state_reg;
    logic [bdh_pkg::TIME_W-1:0]     rd_time_reg;
    logic                           rd_vld_reg;

    // last write-back, for forwarding
    logic                           fwd_valid_reg;
    logic [bdh_pkg::IDX_W-1:0]      fwd_idx_reg;
    bdh_pkg::btn_state_t            fwd_state_reg;
    logic                           fwd_tw_reg;
    logic [bdh_pkg::TIME_W-1:0]     fwd_time_reg;

    // output register
    logic                           out_valid_reg;
    logic [bdh_pkg::IDX_W-1:0]      out_idx_reg;
    bdh_pkg::btn_state_t            out_state_reg;

    logic                           accept;
    logic                           s1_fire;
    logic                           fwd_hit;
    logic                           in_range;
    logic                           pressed;
    bdh_pkg::btn_state_t            cur_state;
    logic [bdh_pkg::TIME_W-1:0]     cur_time;
    logic [bdh_pkg::TIME_W-1:0]     elapsed;
    logic                           deb_over;
    logic                           hold_over;
    bdh_pkg::btn_state_t            state_next;
    logic                           time_we;

    assign s1_fire      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_fire;
    assign accept       = sample.valid && sample.ready;

    assign result.valid     = out_valid_reg;
    assign result.out_index = out_idx_reg;
    assign result.new_state = out_state_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_limit_reg  <= bdh_pkg::DEBOUNCE_LIMIT_RST;
            hold_limit_reg <= bdh_pkg::HOLD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bdh_pkg::REG_DEBOUNCE_LIMIT: deb_limit_reg  <= cfg_data;
                bdh_pkg::REG_HOLD_LIMIT:     hold_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // state/time update
    assign in_range  = {1'b0, s1_idx_reg} < (bdh_pkg::IDX_W+1)'(N);
    assign pressed   = !s1_pin_reg;
    assign fwd_hit   = fwd_valid_reg && (fwd_idx_reg == s1_idx_reg);
    assign cur_state = fwd_hit ? fwd_state_reg
                     : (rd_vld_reg ? rd_state_reg : bdh_pkg::ST_UP);
    assign cur_time  = (fwd_hit && fwd_tw_reg) ? fwd_time_reg : rd_time_reg;
    assign elapsed   = s1_now_reg - cur_time;
    assign deb_over  = elapsed > {{(bdh_pkg::TIME_W-bdh_pkg::LIMIT_W){1'b0}}, deb_limit_reg};
    assign hold_over = elapsed > {{(bdh_pkg::TIME_W-bdh_pkg::LIMIT_W){1'b0}}, hold_limit_reg};

    always_comb
    begin
        state_next = cur_state;
        time_we    = 1'b0;
        unique case (cur_state)
            bdh_pkg::ST_UP:
            begin
                if (pressed)
                begin
                    time_we    = 1'b1;
                    state_next = bdh_pkg::ST_PRESSED;
                end
            end
            bdh_pkg::ST_PRESSED:
                state_next = bdh_pkg::ST_DEBOUNCE;
            bdh_pkg::ST_DEBOUNCE:
            begin
                if (deb_over)
                begin
                    if (pressed)
                    begin
                        time_we    = 1'b1;
                        state_next = bdh_pkg::ST_DOWN;
                    end
                    else
                    begin
                        state_next = bdh_pkg::ST_UP;
                    end
                end
            end
            bdh_pkg::ST_DOWN:
            begin
                if (!pressed)
                    state_next = bdh_pkg::ST_RELEASED;
                else if (hold_over)
                    state_next = bdh_pkg::ST_HELD;
            end
            bdh_pkg::ST_HELD:
            begin
                if (!pressed)
                    state_next = bdh_pkg::ST_UP;
            end
            bdh_pkg::ST_RELEASED:
                state_next = bdh_pkg::ST_UP;
            default:
                state_next = bdh_pkg::ST_UP;
        endcase
        if (!in_range)
        begin
            state_next = bdh_pkg::ST_UP;
            time_we    = 1'b0;
        end
    end

    // memories: read at accept, write back when the compute stage retires
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_state_reg <= state_mem[sample.button_index];
            rd_time_reg  <= time_mem[sample.button_index];
        end
        if (s1_fire && in_range)
        begin
            state_mem[s1_idx_reg] <= state_next;
            if (time_we)
                time_mem[s1_idx_reg] <= s1_now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                rd_vld_reg <= vld_reg[sample.button_index];
            if (s1_fire && in_range)
                vld_reg[s1_idx_reg] <= 1'b1;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s1_fire)
                fwd_valid_reg <= in_range;
            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg <= sample.button_index;
            s1_pin_reg <= sample.pin_level;
            s1_now_reg <= sample.now_ms;
        end
        if (s1_fire)
        begin
            fwd_idx_reg   <= s1_idx_reg;
            fwd_state_reg <= state_next;
            fwd_tw_reg    <= time_we;
            fwd_time_reg  <= s1_now_reg;
            out_idx_reg   <= s1_idx_reg;
            out_state_reg <= state_next;
        end
    end

endmodule
